// File: hdl/sbcd_pkg.sv
`timescale 1ns / 1ps

package sbcd_pkg;

    localparam int unsigned VALUE_W   = 18;
    localparam int unsigned MAG_W     = 17;
    localparam int unsigned CODE_W    = 5;
    localparam int unsigned BCD_W     = 4;
    localparam int unsigned NUM_DIG   = 5;
    localparam int unsigned NUM_CELLS = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(99999);

    // Place values handled by the cells, most significant first.
    localparam int unsigned DIVISORS [NUM_CELLS] = '{10000, 1000, 100, 10};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE = CFG_IDX_W'(1);

    localparam logic [CODE_W-1:0] MINUS_CODE_RST = CODE_W'(25);
    localparam logic [CODE_W-1:0] BLANK_CODE_RST = CODE_W'(26);

    // One beat as it travels down the row of cells.
    typedef struct packed {
        logic                          valid;
        logic                          neg;
        logic                          ovf;
        logic                          blank_tens;
        logic [MAG_W-1:0]              rem;
        logic [NUM_DIG-1:0][BCD_W-1:0] dig;
    } t_stage;

    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] units;
        logic [CODE_W-1:0] tens;
        logic [CODE_W-1:0] hundreds;
        logic [CODE_W-1:0] thousands;
        logic [CODE_W-1:0] ten_thousands;
        logic [CODE_W-1:0] sign;
        logic              ovf;
    } t_result;

endpackage

// File: hdl/signed_bcd_display_digits.sv
`timescale 1ns / 1ps
// o_done strobes once a beat has passed the magnitude, cell and output registers.
// Throughput: one beat per cycle; a row of four digit cells, one per place value,
// carries up to six beats in flight, so o_busy never rises.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is synchronous and active low; it drops all beats in flight and loads
// the minus and blank codes with 25 and 26.

module signed_bcd_display_digits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [sbcd_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_blank_tens,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbcd_pkg::CODE_W-1:0]  i_cfg_data,
    output logic                         o_done,
    output logic [sbcd_pkg::CODE_W-1:0]  o_digit_units,
    output logic [sbcd_pkg::CODE_W-1:0]  o_digit_tens,
    output logic [sbcd_pkg::CODE_W-1:0]  o_digit_hundreds,
    output logic [sbcd_pkg::CODE_W-1:0]  o_digit_thousands,
    output logic [sbcd_pkg::CODE_W-1:0]  o_digit_ten_thousands,
    output logic [sbcd_pkg::CODE_W-1:0]  o_sign_position,
    output logic                         o_overflow
);
    import sbcd_pkg::*;

    logic [CODE_W-1:0] r_minus_code;
    logic [CODE_W-1:0] r_blank_code;
    logic [CODE_W-1:0] n_minus_code;
    logic [CODE_W-1:0] n_blank_code;
    logic              w_accept;
    t_stage            w_chain [NUM_CELLS+1];
    t_result           w_result;

    // Every beat is independent, so the row never has to hold off a new one.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    // Configuration registers; other indexes are dropped. Codes feed only the
    // last stage; the user must change them only while idle, unenforced here.
    always_comb begin
        n_minus_code = r_minus_code;
        n_blank_code = r_blank_code;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MINUS_CODE: n_minus_code = i_cfg_data;
                CFG_BLANK_CODE: n_blank_code = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minus_code <= MINUS_CODE_RST;
            r_blank_code <= BLANK_CODE_RST;
        end else begin
            r_minus_code <= n_minus_code;
            r_blank_code <= n_blank_code;
        end
    end

    // First stage: sign, magnitude and saturation to 99999.
    sbcd_mag u_mag (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_value      (i_value),
        .i_blank_tens (i_blank_tens),
        .o_stage      (w_chain[0])
    );

    // The row of digit cells. Each cell peels off one decimal digit and
    // hands the remainder to its right-hand neighbor every cycle; what is
    // left after the tens cell is the units digit.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        sbcd_digit_cell #(
            .DIVISOR   (DIVISORS[g]),
            .DIGIT_IDX (NUM_DIG - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // Last stage: leading-zero blanking, sign placement and output register.
    sbcd_blank u_blank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (w_chain[NUM_CELLS]),
        .i_minus_code (r_minus_code),
        .i_blank_code (r_blank_code),
        .o_result     (w_result)
    );

    assign o_done                = w_result.done;
    assign o_digit_units         = w_result.units;
    assign o_digit_tens          = w_result.tens;
    assign o_digit_hundreds      = w_result.hundreds;
    assign o_digit_thousands     = w_result.thousands;
    assign o_digit_ten_thousands = w_result.ten_thousands;
    assign o_sign_position       = w_result.sign;
    assign o_overflow            = w_result.ovf;

    // A result only appears for a beat that entered the pipeline at its head.
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 6))
        else $error("result strobe without a matching start");

    // The units position always shows a decimal digit.
    a_units_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_digit_units <= CODE_W'(9)))
        else $error("units position holds a non-digit code");

    // A saturated value shows 99999 in every digit position.
    a_overflow_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |->
            (o_digit_units == CODE_W'(9)) && (o_digit_tens == CODE_W'(9)) &&
            (o_digit_hundreds == CODE_W'(9)) && (o_digit_thousands == CODE_W'(9)) &&
            (o_digit_ten_thousands == CODE_W'(9)))
        else $error("overflow without a saturated display");

    // The sign position output carries one of the two configured codes.
    a_sign_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_sign_position == r_minus_code) || (o_sign_position == r_blank_code))
        else $error("sign position holds an unexpected code");

endmodule

// File: hdl/sbcd_mag.sv
`timescale 1ns / 1ps

module sbcd_mag (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [sbcd_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_blank_tens,
    output sbcd_pkg::t_stage              o_stage
);
    import sbcd_pkg::*;

    logic [VALUE_W-1:0] w_abs;
    t_stage             n_stage;
    t_stage             r_stage;

    // The negation of the most negative pattern stays 2^17, which saturates.
    always_comb begin
        w_abs = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
        n_stage            = '0;
        n_stage.valid      = i_valid;
        n_stage.neg        = i_value[VALUE_W-1];
        n_stage.blank_tens = i_blank_tens;
        if (w_abs > VALUE_W'(MAG_LIMIT)) begin
            n_stage.ovf = 1'b1;
            n_stage.rem = MAG_LIMIT;
        end else begin
            n_stage.ovf = 1'b0;
            n_stage.rem = w_abs[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/sbcd_digit_cell.sv
`timescale 1ns / 1ps

module sbcd_digit_cell #(
    parameter int unsigned DIVISOR   = 10,
    parameter int unsigned DIGIT_IDX = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbcd_pkg::t_stage i_stage,
    output sbcd_pkg::t_stage o_stage
);
    import sbcd_pkg::*;

    logic [BCD_W-1:0] w_digit;
    logic [MAG_W-1:0] w_sub;
    t_stage           n_stage;
    t_stage           r_stage;

    // The remainder entering a cell is below ten times its place value, so
    // the digit is the largest multiple that still fits.
    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int k = 1; k <= 9; k++) begin
            if (i_stage.rem >= MAG_W'(k * DIVISOR)) begin
                w_digit = BCD_W'(k);
                w_sub   = MAG_W'(k * DIVISOR);
            end
        end
        n_stage                = i_stage;
        n_stage.rem            = i_stage.rem - w_sub;
        n_stage.dig[DIGIT_IDX] = w_digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/sbcd_blank.sv
`timescale 1ns / 1ps

module sbcd_blank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbcd_pkg::t_stage            i_stage,
    input  logic [sbcd_pkg::CODE_W-1:0] i_minus_code,
    input  logic [sbcd_pkg::CODE_W-1:0] i_blank_code,
    output sbcd_pkg::t_result           o_result
);
    import sbcd_pkg::*;

    logic [CODE_W-1:0] w_sign;
    t_result           n_result;
    t_result           r_result;

    // Leading zeros are blanked from the top down; the sign code sits in the
    // rightmost blanked position, just left of the first shown digit.
    always_comb begin
        w_sign                 = i_stage.neg ? i_minus_code : i_blank_code;
        n_result.done          = i_stage.valid;
        n_result.ovf           = i_stage.ovf;
        n_result.sign          = w_sign;
        n_result.units         = CODE_W'(i_stage.rem[BCD_W-1:0]);
        n_result.tens          = CODE_W'(i_stage.dig[1]);
        n_result.hundreds      = CODE_W'(i_stage.dig[2]);
        n_result.thousands     = CODE_W'(i_stage.dig[3]);
        n_result.ten_thousands = CODE_W'(i_stage.dig[4]);
        if (i_stage.dig[4] == '0) begin
            n_result.ten_thousands = w_sign;
            if (i_stage.dig[3] == '0) begin
                n_result.thousands     = w_sign;
                n_result.ten_thousands = i_blank_code;
                if (i_stage.dig[2] == '0) begin
                    n_result.hundreds  = w_sign;
                    n_result.thousands = i_blank_code;
                    if (i_stage.blank_tens && (i_stage.dig[1] == '0)) begin
                        n_result.tens     = w_sign;
                        n_result.hundreds = i_blank_code;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result <= '0;
        end else begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// File: bench/tb_signed_bcd_display_digits.sv
`timescale 1ns / 1ps

module tb_signed_bcd_display_digits;

    import sbcd_pkg::*;

    localparam int unsigned MAX_SHOWN       = 99999;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    // Idle time at the end, enough for the block's pipeline to drain.
    localparam int unsigned DRAIN_CYCLES    = 12;
    // Watchdog limit, several times the slowest legal run.
    localparam int unsigned TIMEOUT_NS      = 2_000_000;

    // Indexes past the end of the register list. Writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = CFG_IDX_W'(3);

    // One conversion request, as carried by one beat on the command side.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      blank_tens;
    } display_req_t;

    // The six codes and the overflow flag that the block shows for one request.
    typedef struct packed {
        logic [CODE_W-1:0] units;
        logic [CODE_W-1:0] tens;
        logic [CODE_W-1:0] hundreds;
        logic [CODE_W-1:0] thousands;
        logic [CODE_W-1:0] ten_thousands;
        logic [CODE_W-1:0] sign;
        logic              ovf;
    } digit_codes_t;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_start      = 1'b0;
    logic signed [VALUE_W-1:0] i_value      = '0;
    logic                      i_blank_tens = 1'b0;
    logic                      i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = '0;
    logic [CODE_W-1:0]         i_cfg_data   = '0;

    logic                      o_busy;
    logic                      o_cfg_ready;
    logic                      o_done;
    logic [CODE_W-1:0]         o_digit_units;
    logic [CODE_W-1:0]         o_digit_tens;
    logic [CODE_W-1:0]         o_digit_hundreds;
    logic [CODE_W-1:0]         o_digit_thousands;
    logic [CODE_W-1:0]         o_digit_ten_thousands;
    logic [CODE_W-1:0]         o_sign_position;
    logic                      o_overflow;

    // Requests waiting to be driven, and codes waiting to come back.
    display_req_t pending_reqs[$];
    digit_codes_t expected_codes[$];

    // Our own copy of the two symbol registers, updated on each accepted write.
    logic [CODE_W-1:0] minus_sym = MINUS_CODE_RST;
    logic [CODE_W-1:0] blank_sym = BLANK_CODE_RST;

    logic        beat_taken = 1'b0;
    bit          gaps_on    = 1'b1;
    int unsigned gap_odds   = 4;
    int unsigned gap_left   = 0;
    int unsigned issued     = 0;
    int unsigned accepted   = 0;
    int unsigned checked    = 0;
    int unsigned negatives  = 0;
    int unsigned saturated  = 0;
    int unsigned settings   = 1;
    int unsigned errors     = 0;

    signed_bcd_display_digits u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_value               (i_value),
        .i_blank_tens          (i_blank_tens),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_digit_units         (o_digit_units),
        .o_digit_tens          (o_digit_tens),
        .o_digit_hundreds      (o_digit_hundreds),
        .o_digit_thousands     (o_digit_thousands),
        .o_digit_ten_thousands (o_digit_ten_thousands),
        .o_sign_position       (o_sign_position),
        .o_overflow            (o_overflow)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Works out the codes the block must show for one request. The magnitude
    // of a negative value is taken modulo 2^18, so the most negative pattern
    // comes out as 131072 and saturates like any other large magnitude.
    function automatic digit_codes_t predict_codes(input display_req_t req,
                                                   input logic [CODE_W-1:0] minus_code,
                                                   input logic [CODE_W-1:0] blank_code);
        logic [VALUE_W-1:0] mag;
        logic [CODE_W-1:0]  sign_code;
        int unsigned        rest;
        int unsigned        d4, d3, d2, d1, d0;
        digit_codes_t       codes;
        mag = req.value;
        if (req.value[VALUE_W-1]) begin
            mag = -mag;
        end
        codes.ovf = (mag > MAX_SHOWN);
        rest      = codes.ovf ? MAX_SHOWN : 32'(mag);
        sign_code = req.value[VALUE_W-1] ? minus_code : blank_code;

        d4   = rest / 10000;
        rest = rest % 10000;
        d3   = rest / 1000;
        rest = rest % 1000;
        d2   = rest / 100;
        rest = rest % 100;
        d1   = rest / 10;
        d0   = rest % 10;

        codes.units         = CODE_W'(d0);
        codes.tens          = CODE_W'(d1);
        codes.hundreds      = CODE_W'(d2);
        codes.thousands     = CODE_W'(d3);
        codes.ten_thousands = CODE_W'(d4);
        codes.sign          = sign_code;

        // Leading zeros are blanked from the top down; when any are, the sign code
        // sits just left of the first shown digit. The tens digit only joins
        // in when asked to and when everything above it is already blank.
        if (d4 == 0) begin
            codes.ten_thousands = sign_code;
            if (d3 == 0) begin
                codes.thousands     = sign_code;
                codes.ten_thousands = blank_code;
                if (d2 == 0) begin
                    codes.hundreds  = sign_code;
                    codes.thousands = blank_code;
                    if (req.blank_tens && d1 == 0) begin
                        codes.tens     = sign_code;
                        codes.hundreds = blank_code;
                    end
                end
            end
        end
        return codes;
    endfunction

    // Random requests lean toward small magnitudes and zero digits, where the
    // blanking logic does its work, but also cover the saturation edge and
    // any 18-bit pattern at all.
    function automatic display_req_t random_request();
        display_req_t req;
        int unsigned  mag;
        int           k;
        mag = 0;
        case ($urandom_range(0, 9))
            0, 1: mag = $urandom_range(0, 99);
            2: mag = $urandom_range(100, 999);
            3: mag = $urandom_range(1000, 9999);
            4, 5: mag = $urandom_range(0, MAX_SHOWN);
            6: mag = $urandom_range(MAX_SHOWN - 10, MAX_SHOWN + 10);
            7: begin
                for (k = 0; k < 5; k++) begin
                    mag = mag * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 9));
                end
            end
            default: mag = $urandom;
        endcase
        req.value = VALUE_W'(mag);
        if ($urandom_range(0, 1)) begin
            req.value = -req.value;
        end
        req.blank_tens = 1'($urandom_range(0, 1));
        return req;
    endfunction

    task automatic queue_request(input int value, input bit blank_tens);
        display_req_t req;
        req.value      = VALUE_W'(value);
        req.blank_tens = blank_tens;
        pending_reqs.push_back(req);
    endtask

    // One write beat on the register channel, held until the block takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CODE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The block is idle once every request has been taken and every result seen.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || issued != accepted || expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Driver. Inputs move on the falling edge. A beat stays up until the block
    // takes it; after each beat a burst of idle cycles may follow, during which
    // the data ports carry junk that the block must ignore.
    always @(negedge i_clk) begin
        display_req_t req;
        if (i_rst_n && (!i_start || beat_taken)) begin
            if (gap_left > 0) begin
                i_start      <= 1'b0;
                i_value      <= VALUE_W'($urandom);
                i_blank_tens <= 1'($urandom_range(0, 1));
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                req = pending_reqs.pop_front();
                i_start      <= 1'b1;
                i_value      <= req.value;
                i_blank_tens <= req.blank_tens;
                issued++;
                if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
                    gap_left = $urandom_range(1, 18);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor. Everything is sampled on the rising edge. A result strobe is
    // checked against the oldest expectation before the beat taken on the same
    // edge is predicted, since that beat cannot have produced it yet.
    always @(posedge i_clk) begin
        digit_codes_t want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MINUS_CODE) begin
                    minus_sym = i_cfg_data;
                end else if (i_cfg_index == CFG_BLANK_CODE) begin
                    blank_sym = i_cfg_data;
                end
            end

            if (o_done !== 1'b0) begin
                if (expected_codes.size() == 0) begin
                    $error("result strobe with no conversion outstanding");
                    errors++;
                end else begin
                    want = expected_codes.pop_front();
                    check_field("digit_units", want.units, o_digit_units);
                    check_field("digit_tens", want.tens, o_digit_tens);
                    check_field("digit_hundreds", want.hundreds, o_digit_hundreds);
                    check_field("digit_thousands", want.thousands, o_digit_thousands);
                    check_field("digit_ten_thousands", want.ten_thousands,
                                o_digit_ten_thousands);
                    check_field("sign_position", want.sign, o_sign_position);
                    check_field("overflow", CODE_W'(want.ovf), CODE_W'(o_overflow));
                    checked++;
                end
            end

            if (i_start && !o_busy) begin
                want = predict_codes({i_value, i_blank_tens}, minus_sym, blank_sym);
                expected_codes.push_back(want);
                accepted++;
                if (i_value[VALUE_W-1]) begin
                    negatives++;
                end
                if (want.ovf) begin
                    saturated++;
                end
            end
            beat_taken <= i_start && !o_busy;
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset codes: zero both ways, each place
        // where blanking stops, inner zeros that must stay, the largest shown
        // magnitude, the first saturated one, and the most negative pattern.
        queue_request(0, 1'b0);
        queue_request(0, 1'b1);
        queue_request(1, 1'b0);
        queue_request(-1, 1'b1);
        queue_request(5, 1'b1);
        queue_request(-7, 1'b0);
        queue_request(10, 1'b1);
        queue_request(-20, 1'b1);
        queue_request(50, 1'b0);
        queue_request(100, 1'b1);
        queue_request(-305, 1'b1);
        queue_request(1000, 1'b0);
        queue_request(-1004, 1'b1);
        queue_request(9999, 1'b0);
        queue_request(-10000, 1'b1);
        queue_request(10005, 1'b1);
        queue_request(99999, 1'b0);
        queue_request(-99999, 1'b1);
        queue_request(100000, 1'b0);
        queue_request(-100001, 1'b0);
        queue_request(131071, 1'b1);
        queue_request(-131072, 1'b1);
        queue_request(-131072, 1'b0);
        wait_idle();

        // Each phase loads new symbol codes while the block is idle, then runs
        // a batch of random requests. The first phases hit the extreme codes,
        // including codes that look like digits. The last phase runs flat out.
        for (phase = 1; phase <= NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_MINUS_CODE, '0);
                    write_reg(CFG_BLANK_CODE, '0);
                end
                2: begin
                    write_reg(CFG_MINUS_CODE, '1);
                    write_reg(CFG_BLANK_CODE, '1);
                    write_reg(CFG_UNMAPPED_A, CODE_W'($urandom));
                end
                3: begin
                    write_reg(CFG_BLANK_CODE, '0);
                    write_reg(CFG_UNMAPPED_B, CODE_W'($urandom));
                end
                default: begin
                    write_reg(CFG_MINUS_CODE, CODE_W'($urandom));
                    write_reg(CFG_BLANK_CODE, CODE_W'($urandom));
                    write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                              CODE_W'($urandom));
                end
            endcase
            settings++;
            gaps_on  = (phase != NUM_PHASES);
            gap_odds = $urandom_range(1, 10);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pending_reqs.push_back(random_request());
            end
            wait_idle();
        end

        // Let any stray strobe show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d conversions under %0d symbol code settings.", checked, settings);
        $display("%0d of them were negative and %0d saturated at the display limit.",
                 negatives, saturated);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
